FILE: hdl/reu_pkg.sv
// ----------------------------------------------------------------------------
// reu_pkg
// Shared types, opcodes and helpers for the 16-register execute unit.
// ----------------------------------------------------------------------------
package reu_pkg;

    // datapath widths
    localparam int XLEN          = 32;
    localparam int PC_W          = 12;
    localparam int IMM_W         = 12;
    localparam int OP_W          = 4;
    localparam int SH_W          = 5;
    localparam int NUM_REGS      = 16;
    localparam int RIDX_W        = $clog2(NUM_REGS);
    localparam int DEF_MEM_WORDS = 4096;

    // register file read ports
    localparam int RF_RPORTS = 4;
    localparam int RP_A      = 0;
    localparam int RP_B      = 1;
    localparam int RP_M      = 2;
    localparam int RP_D      = 3;

    // opcodes
    localparam logic [OP_W-1:0] OP_ADD    = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB    = 4'd1;
    localparam logic [OP_W-1:0] OP_AND    = 4'd2;
    localparam logic [OP_W-1:0] OP_OR     = 4'd3;
    localparam logic [OP_W-1:0] OP_SLL    = 4'd4;
    localparam logic [OP_W-1:0] OP_SRA    = 4'd5;
    localparam logic [OP_W-1:0] OP_MAC    = 4'd6;
    localparam logic [OP_W-1:0] OP_BRANCH = 4'd7;
    localparam logic [OP_W-1:0] OP_JAL    = 4'd11;
    localparam logic [OP_W-1:0] OP_LW     = 4'd12;
    localparam logic [OP_W-1:0] OP_SW     = 4'd13;
    localparam logic [OP_W-1:0] OP_JR     = 4'd14;
    localparam logic [OP_W-1:0] OP_HALT   = 4'd15;

    // branch conditions, signed compares
    localparam logic [RIDX_W-1:0] COND_EQ = 4'd0;
    localparam logic [RIDX_W-1:0] COND_NE = 4'd1;
    localparam logic [RIDX_W-1:0] COND_GT = 4'd2;
    localparam logic [RIDX_W-1:0] COND_LT = 4'd3;
    localparam logic [RIDX_W-1:0] COND_GE = 4'd4;
    localparam logic [RIDX_W-1:0] COND_LE = 4'd5;

    // jal link register
    localparam logic [RIDX_W-1:0] LINK_REG = 4'd15;

    // where a result value comes from once the instruction leaves execute
    typedef enum logic [1:0] {
        RES_ALU,
        RES_MAC,
        RES_LOAD
    } res_kind_t;

    // input transaction
    typedef struct packed {
        logic [OP_W-1:0]   cmd;
        logic [RIDX_W-1:0] dest_reg;
        logic [RIDX_W-1:0] src_a_reg;
        logic [RIDX_W-1:0] src_b_reg;
        logic [RIDX_W-1:0] extra_reg;
        logic [IMM_W-1:0]  immediate;
    } instr_t;

    // output transaction
    typedef struct packed {
        logic [PC_W-1:0]   next_pc;
        logic              halted;
        logic              reg_write;
        logic [RIDX_W-1:0] written_index;
        logic signed [XLEN-1:0] written_value;
    } result_t;

    // register file write port
    typedef struct packed {
        logic              en;
        logic [RIDX_W-1:0] idx;
        logic [XLEN-1:0]   data;
    } rf_wr_t;

    // instruction between execute and the result stage
    typedef struct packed {
        res_kind_t         kind;
        logic              reg_write;
        logic [RIDX_W-1:0] widx;
        logic [XLEN-1:0]   value;
        logic [XLEN-1:0]   mul_a;
        logic [XLEN-1:0]   mul_b;
        logic [PC_W-1:0]   next_pc;
        logic              halted;
    } mid_t;

    // sign-extend the 12-bit immediate
    function automatic logic [XLEN-1:0] sext_imm(input logic [IMM_W-1:0] imm);
        return {{(XLEN-IMM_W){imm[IMM_W-1]}}, imm};
    endfunction

endpackage

FILE: hdl/reu_regfile.sv
// ----------------------------------------------------------------------------
// reu_regfile
// 16 x 32 register file: two mirrored banks with two synchronous read ports
// each, write-first on a same-address write, per-entry valid bits so that
// entries never written read as zero.
// ----------------------------------------------------------------------------
module reu_regfile (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              rd_en,
    input  logic [reu_pkg::RF_RPORTS-1:0][reu_pkg::RIDX_W-1:0] rd_idx,
    output logic [reu_pkg::RF_RPORTS-1:0][reu_pkg::XLEN-1:0]   rd_data,
    input  reu_pkg::rf_wr_t                                   wr
);

    logic [reu_pkg::XLEN-1:0] bank_lo_mem [reu_pkg::NUM_REGS];
    logic [reu_pkg::XLEN-1:0] bank_hi_mem [reu_pkg::NUM_REGS];

    logic [reu_pkg::NUM_REGS-1:0]                          vld_reg;
    logic [reu_pkg::RF_RPORTS-1:0]                         hit_vld_reg;
    logic [reu_pkg::RF_RPORTS-1:0][reu_pkg::XLEN-1:0]      raw_reg;

    // valid bits and the valid flag sampled with each read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            hit_vld_reg <= '0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.idx] <= 1'b1;
            end
            if (rd_en)
            begin
                for (int p = 0; p < reu_pkg::RF_RPORTS; p++)
                begin
                    hit_vld_reg[p] <= vld_reg[rd_idx[p]] || (wr.en && (wr.idx == rd_idx[p]));
                end
            end
        end
    end

    // bank writes and reads, low bank serves ports a/b, high bank m/d
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            bank_lo_mem[wr.idx] <= wr.data;
            bank_hi_mem[wr.idx] <= wr.data;
        end
        if (rd_en)
        begin
            for (int p = 0; p < reu_pkg::RF_RPORTS / 2; p++)
            begin
                raw_reg[p] <= (wr.en && (wr.idx == rd_idx[p])) ? wr.data
                                                                : bank_lo_mem[rd_idx[p]];
            end
            for (int p = reu_pkg::RF_RPORTS / 2; p < reu_pkg::RF_RPORTS; p++)
            begin
                raw_reg[p] <= (wr.en && (wr.idx == rd_idx[p])) ? wr.data
                                                                : bank_hi_mem[rd_idx[p]];
            end
        end
    end

    // unwritten entries read as zero
    always_comb
    begin
        for (int p = 0; p < reu_pkg::RF_RPORTS; p++)
        begin
            rd_data[p] = hit_vld_reg[p] ? raw_reg[p] : '0;
        end
    end

endmodule

FILE: hdl/risc_execute_unit_16reg.sv
// ----------------------------------------------------------------------------
// risc_execute_unit_16reg
// Execute unit of a small 16-register machine with a 12-bit program counter
// and a word-addressed data memory.
// ----------------------------------------------------------------------------
// Usage:
//   instr carries one decoded instruction per transaction (instr_valid /
//   instr_stall); result carries one transaction per instruction with the
//   next pc, the halt flag and any register write (result_valid /
//   result_stall). Results leave in instruction order.
//   From the accepting edge to the result being offered an instruction passes
//   register read and execute (alu, branch, memory access), then
//   multiply-accumulate or load return into the output register.
//   Throughput is one instruction per cycle unless result_stall or the mac
//   interlock holds it: an instruction that reads the destination of a mac
//   directly ahead of it waits until that mac moves on, as the mac sum is
//   formed only in the last stage; other dependences bypass the register file.
//   Reset clears the registers to zero, the pc to zero and empties the
//   pipeline; data memory words read before any store are undefined.
//   MEM_WORDS must be a power of two. When result_stall is high the output
//   holds and the stages behind it fill, after which instr_stall rises.
// ----------------------------------------------------------------------------
module risc_execute_unit_16reg #(
    parameter int MEM_WORDS = reu_pkg::DEF_MEM_WORDS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             instr_valid,
    output logic             instr_stall,
    input  reu_pkg::instr_t  instr,
    output logic             result_valid,
    input  logic             result_stall,
    output reu_pkg::result_t result
);

    localparam int AW = $clog2(MEM_WORDS);

    // pipeline control
    logic s3_free, s2_free, s2_adv, s1_adv, s1_free, accept, hazard;

    // register read stage
    logic                                                s1_valid_reg;
    logic                                                s1_fresh_reg;
    reu_pkg::instr_t                                     s1_reg;
    logic [reu_pkg::RF_RPORTS-1:0][reu_pkg::RIDX_W-1:0]  rd_idx;
    logic [reu_pkg::RF_RPORTS-1:0][reu_pkg::RIDX_W-1:0]  s1_idx;
    logic [reu_pkg::RF_RPORTS-1:0][reu_pkg::XLEN-1:0]    rf_rdata;
    logic [reu_pkg::RF_RPORTS-1:0][reu_pkg::XLEN-1:0]    ops_reg;
    logic [reu_pkg::RF_RPORTS-1:0][reu_pkg::XLEN-1:0]    ops_next;
    logic [reu_pkg::RF_RPORTS-1:0]                       ops_use;
    reu_pkg::rf_wr_t                                     rf_wr;

    // forwarding sources
    logic                     s2_fwd_ok, s3_fwd_ok;
    logic [reu_pkg::XLEN-1:0] s2_fwd_val;

    // execute
    logic [reu_pkg::XLEN-1:0] op_a, op_b, op_m, op_d, simm;
    logic [reu_pkg::SH_W-1:0] shamt;
    logic [reu_pkg::PC_W-1:0] pc_reg, pc_inc, addr12;
    logic [AW-1:0]            maddr;
    logic                     taken;
    reu_pkg::mid_t            s2_next;

    // memory / result stages
    logic [reu_pkg::XLEN-1:0] dmem [MEM_WORDS];
    logic [reu_pkg::XLEN-1:0] load_data_reg;
    logic                     s2_valid_reg;
    reu_pkg::mid_t            s2_reg;
    logic [reu_pkg::XLEN-1:0] mac_prod, s2_value;
    logic                     s3_valid_reg;
    reu_pkg::result_t         s3_reg;
    reu_pkg::result_t         s3_next;

    // handshake through the three stages
    assign s3_free     = !s3_valid_reg || !result_stall;
    assign s2_free     = !s2_valid_reg || s3_free;
    assign s2_adv      = s2_valid_reg && s3_free;
    assign s1_adv      = s1_valid_reg && s2_free && !hazard;
    assign s1_free     = !s1_valid_reg || s1_adv;
    assign accept      = instr_valid && s1_free;
    assign instr_stall = !s1_free;

    assign result_valid = s3_valid_reg;
    assign result       = s3_reg;

    // register file write on retirement of a result transaction
    always_comb
    begin
        rf_wr.en   = s3_valid_reg && !result_stall && s3_reg.reg_write;
        rf_wr.idx  = s3_reg.written_index;
        rf_wr.data = $unsigned(s3_reg.written_value);
    end

    // read addresses of the incoming and the waiting instruction
    always_comb
    begin
        rd_idx[reu_pkg::RP_A] = instr.src_a_reg;
        rd_idx[reu_pkg::RP_B] = instr.src_b_reg;
        rd_idx[reu_pkg::RP_M] = instr.extra_reg;
        rd_idx[reu_pkg::RP_D] = instr.dest_reg;
        s1_idx[reu_pkg::RP_A] = s1_reg.src_a_reg;
        s1_idx[reu_pkg::RP_B] = s1_reg.src_b_reg;
        s1_idx[reu_pkg::RP_M] = s1_reg.extra_reg;
        s1_idx[reu_pkg::RP_D] = s1_reg.dest_reg;
    end

    reu_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_idx  (rd_idx),
        .rd_data (rf_rdata),
        .wr      (rf_wr)
    );

    // operand forwarding, youngest producer first
    always_comb
    begin
        s2_fwd_ok  = s2_valid_reg && s2_reg.reg_write && (s2_reg.kind != reu_pkg::RES_MAC);
        s2_fwd_val = (s2_reg.kind == reu_pkg::RES_LOAD) ? load_data_reg : s2_reg.value;
        s3_fwd_ok  = s3_valid_reg && s3_reg.reg_write;
        for (int p = 0; p < reu_pkg::RF_RPORTS; p++)
        begin
            if (s2_fwd_ok && (s2_reg.widx == s1_idx[p]))
            begin
                ops_next[p] = s2_fwd_val;
            end
            else if (s3_fwd_ok && (s3_reg.written_index == s1_idx[p]))
            begin
                ops_next[p] = $unsigned(s3_reg.written_value);
            end
            else
            begin
                ops_next[p] = s1_fresh_reg ? rf_rdata[p] : ops_reg[p];
            end
        end
    end

    // interlock behind a mac whose sum is not ready yet
    always_comb
    begin
        ops_use[reu_pkg::RP_A] = 1'b1;
        ops_use[reu_pkg::RP_B] = 1'b1;
        ops_use[reu_pkg::RP_M] = (s1_reg.cmd == reu_pkg::OP_MAC);
        ops_use[reu_pkg::RP_D] = (s1_reg.cmd == reu_pkg::OP_SW) ||
                                 (s1_reg.cmd == reu_pkg::OP_JR);
        hazard = 1'b0;
        for (int p = 0; p < reu_pkg::RF_RPORTS; p++)
        begin
            if (s1_valid_reg && s2_valid_reg && s2_reg.reg_write &&
                (s2_reg.kind == reu_pkg::RES_MAC) && ops_use[p] &&
                (s2_reg.widx == s1_idx[p]))
            begin
                hazard = 1'b1;
            end
        end
    end

    // operands, shift amount, memory address and branch compare
    always_comb
    begin
        op_a   = ops_next[reu_pkg::RP_A];
        op_b   = ops_next[reu_pkg::RP_B];
        op_m   = ops_next[reu_pkg::RP_M];
        op_d   = ops_next[reu_pkg::RP_D];
        simm   = reu_pkg::sext_imm(s1_reg.immediate);
        shamt  = reu_pkg::SH_W'(op_b[reu_pkg::SH_W-1:0] +
                                s1_reg.immediate[reu_pkg::SH_W-1:0]);
        pc_inc = pc_reg + reu_pkg::PC_W'(1);
        addr12 = reu_pkg::PC_W'(op_a + simm);
        // word index modulo the power-of-two memory size
        maddr  = AW'(addr12);
        case (s1_reg.extra_reg)
            reu_pkg::COND_EQ: taken = (op_a == op_b);
            reu_pkg::COND_NE: taken = (op_a != op_b);
            reu_pkg::COND_GT: taken = ($signed(op_a) >  $signed(op_b));
            reu_pkg::COND_LT: taken = ($signed(op_a) <  $signed(op_b));
            reu_pkg::COND_GE: taken = ($signed(op_a) >= $signed(op_b));
            reu_pkg::COND_LE: taken = ($signed(op_a) <= $signed(op_b));
            default:          taken = 1'b0;
        endcase
    end

    // instruction decode and alu
    always_comb
    begin
        s2_next.kind      = reu_pkg::RES_ALU;
        s2_next.reg_write = 1'b0;
        s2_next.widx      = '0;
        s2_next.value     = '0;
        s2_next.mul_a     = op_a;
        s2_next.mul_b     = op_b;
        s2_next.next_pc   = pc_inc;
        s2_next.halted    = 1'b0;
        unique case (s1_reg.cmd)
            reu_pkg::OP_ADD:
            begin
                s2_next.reg_write = 1'b1;
                s2_next.widx      = s1_reg.dest_reg;
                s2_next.value     = op_a + op_b + simm;
            end
            reu_pkg::OP_SUB:
            begin
                s2_next.reg_write = 1'b1;
                s2_next.widx      = s1_reg.dest_reg;
                s2_next.value     = op_a - op_b - simm;
            end
            reu_pkg::OP_AND:
            begin
                s2_next.reg_write = 1'b1;
                s2_next.widx      = s1_reg.dest_reg;
                s2_next.value     = op_a & op_b & simm;
            end
            reu_pkg::OP_OR:
            begin
                s2_next.reg_write = 1'b1;
                s2_next.widx      = s1_reg.dest_reg;
                s2_next.value     = op_a | op_b | simm;
            end
            reu_pkg::OP_SLL:
            begin
                s2_next.reg_write = 1'b1;
                s2_next.widx      = s1_reg.dest_reg;
                s2_next.value     = op_a << shamt;
            end
            reu_pkg::OP_SRA:
            begin
                s2_next.reg_write = 1'b1;
                s2_next.widx      = s1_reg.dest_reg;
                s2_next.value     = $unsigned($signed(op_a) >>> shamt);
            end
            reu_pkg::OP_MAC:
            begin
                s2_next.kind      = reu_pkg::RES_MAC;
                s2_next.reg_write = 1'b1;
                s2_next.widx      = s1_reg.dest_reg;
                s2_next.value     = op_m + simm;
            end
            reu_pkg::OP_BRANCH:
            begin
                if (taken)
                begin
                    s2_next.next_pc = s1_reg.immediate;
                end
            end
            reu_pkg::OP_JAL:
            begin
                s2_next.reg_write = 1'b1;
                s2_next.widx      = reu_pkg::LINK_REG;
                s2_next.value     = reu_pkg::XLEN'(pc_inc);
                s2_next.next_pc   = s1_reg.immediate;
            end
            reu_pkg::OP_LW:
            begin
                s2_next.kind      = reu_pkg::RES_LOAD;
                s2_next.reg_write = 1'b1;
                s2_next.widx      = s1_reg.dest_reg;
            end
            reu_pkg::OP_SW:
            begin
                s2_next.next_pc = pc_inc;
            end
            reu_pkg::OP_JR:
            begin
                s2_next.next_pc = op_d[reu_pkg::PC_W-1:0];
            end
            reu_pkg::OP_HALT:
            begin
                s2_next.halted  = 1'b1;
                s2_next.next_pc = pc_reg;
            end
            default:
            begin
                s2_next.next_pc = pc_reg;
            end
        endcase
    end

    // data memory: store and load issued as the instruction leaves execute
    always_ff @(posedge clk)
    begin
        if (s1_adv && (s1_reg.cmd == reu_pkg::OP_SW))
        begin
            dmem[maddr] <= op_d;
        end
        if (s1_adv && (s1_reg.cmd == reu_pkg::OP_LW))
        begin
            load_data_reg <= dmem[maddr];
        end
    end

    // multiply-accumulate and result select
    always_comb
    begin
        mac_prod = s2_reg.mul_a * s2_reg.mul_b;
        case (s2_reg.kind)
            reu_pkg::RES_MAC:  s2_value = mac_prod + s2_reg.value;
            reu_pkg::RES_LOAD: s2_value = load_data_reg;
            default:           s2_value = s2_reg.value;
        endcase
        s3_next.next_pc       = s2_reg.next_pc;
        s3_next.halted        = s2_reg.halted;
        s3_next.reg_write     = s2_reg.reg_write;
        s3_next.written_index = s2_reg.widx;
        s3_next.written_value = $signed(s2_value);
    end

    // stage valids and program counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_fresh_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            pc_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_fresh_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            else if (s1_valid_reg)
            begin
                s1_fresh_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                s2_valid_reg <= 1'b1;
                pc_reg       <= s2_next.next_pc;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_adv)
            begin
                s3_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                s3_valid_reg <= 1'b0;
            end
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= instr;
        end
        if (s1_valid_reg && !s1_adv)
        begin
            ops_reg <= ops_next;
        end
        if (s1_adv)
        begin
            s2_reg <= s2_next;
        end
        if (s2_adv)
        begin
            s3_reg <= s3_next;
        end
    end

endmodule

FILE: hdl/reu_checker.sv
// ----------------------------------------------------------------------------
// reu_checker
// Port-level checks on the execute unit's result channel.
// ----------------------------------------------------------------------------
module reu_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             instr_stall,
    input reu_pkg::result_t result,
    input logic             result_valid,
    input logic             result_stall
);

    // a stalled result stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result_valid dropped while stalled");

    // a stalled result keeps its payload
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result payload changed while stalled");

    // halt never writes a register
    a_halt_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.halted |-> !result.reg_write)
        else $error("halt reported a register write");

    // no write means index and value are zero
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.reg_write |->
            (result.written_index == '0) && (result.written_value == '0))
        else $error("write fields not cleared without a register write");

    // handshake outputs are always driven to known levels out of reset
    a_handshake_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({instr_stall, result_valid}))
        else $error("handshake output unknown");

endmodule

bind risc_execute_unit_16reg reu_checker u_reu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .instr_stall  (instr_stall),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
);
